@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the button qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/bclp_pkg.sv @@
// ----------------------------------------------------------------------------
// bclp_pkg
// Types and constants shared by the button click / long-press qualifier.
// ----------------------------------------------------------------------------
package bclp_pkg;

    localparam int unsigned LINE_W    = 4;
    localparam int unsigned SEL_W     = 3;
    localparam int unsigned COUNT_W   = 11;
    localparam int unsigned FILTER_W  = 4;
    localparam int unsigned GAP_W     = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 11;

    localparam logic [SEL_W-1:0]   SELECT_RESET    = 3'd1;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 11'd750;
    localparam logic [FILTER_W-1:0] FILTER_RESET   = 4'd2;
    localparam logic [GAP_W-1:0]   GAP_RESET       = 8'd50;

    // Hold cap of the click machine and of the long-press fired phase
    localparam logic [COUNT_W-1:0] HOLD_CAP      = 11'd2000;
    localparam logic [COUNT_W-1:0] LONG_HOLD_CAP = 11'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUTTON_SELECT  = 2'd0,
        CFG_LONG_THRESHOLD = 2'd1,
        CFG_PRESS_FILTER   = 2'd2,
        CFG_RELEASE_GAP    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        CLICK_IDLE    = 2'd0,
        CLICK_HELD    = 2'd1,
        CLICK_LOCKOUT = 2'd2
    } click_phase_t;

    typedef enum logic [1:0] {
        LONG_IDLE    = 2'd0,
        LONG_FIRED   = 2'd1,
        LONG_LOCKOUT = 2'd2
    } long_phase_t;

    typedef struct packed {
        logic [SEL_W-1:0]    button_select;
        logic [COUNT_W-1:0]  long_threshold;
        logic [FILTER_W-1:0] press_filter;
        logic [GAP_W-1:0]    release_gap;
    } bclp_cfg_t;

    // Click machine to long-press machine, and click to result register
    typedef struct packed {
        logic click;
        logic clear_all;
    } click_status_t;

endpackage

@@ rtl/core/bclp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// bclp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bclp_cfg_if;
    logic                                valid;
    logic                                ready;
    bclp_pkg::cfg_index_t                index;
    logic [bclp_pkg::CFG_DAT_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/bclp_in_if.sv @@
// ----------------------------------------------------------------------------
// bclp_in_if
// Input channel: one polling tick of the four button lines.
// ----------------------------------------------------------------------------
interface bclp_in_if;
    logic                             valid;
    logic                             ready;
    logic [bclp_pkg::LINE_W-1:0]      line_levels;

    modport source (output valid, output line_levels, input ready);
    modport sink   (input valid, input line_levels, output ready);
endinterface

@@ rtl/core/bclp_out_if.sv @@
// ----------------------------------------------------------------------------
// bclp_out_if
// Result channel: click and long-press flags of one tick.
// ----------------------------------------------------------------------------
interface bclp_out_if;
    logic valid;
    logic ready;
    logic click;
    logic long_press;

    modport source (output valid, output click, output long_press, input ready);
    modport sink   (input valid, input click, input long_press, output ready);
endinterface

@@ rtl/core/button_click_long_press_qualifier.sv @@
// ----------------------------------------------------------------------------
// button_click_long_press_qualifier
// Debounced short-click and long-press detector for one of four button lines.
// ----------------------------------------------------------------------------
// Usage:
//   button : one transfer per polling tick carrying line_levels, four
//            active-low lines (bit i is button i+1, 0 means pressed).
//   result : exactly one transfer per input transfer, with click and
//            long_press flags for that tick, in input order.
//   cfg    : register writes (index 0 button_select, 1 long_threshold,
//            2 press_filter, 3 release_gap); always ready. Write only while
//            no tick is in flight.
//   The result of a tick accepted at one edge shows on result from the next
//   cycle. Throughput is one tick per cycle while the receiver takes each
//   result, set by the single result register that parts the two channels.
//   When the receiver stalls, the pending result holds and button drops
//   ready until that result is taken; a result taken in the same cycle frees
//   the slot, so back-to-back transfers continue.
//   Reset clears both machines, the result valid flag and loads the register
//   defaults 1, 750, 2 and 50.
// ----------------------------------------------------------------------------
module button_click_long_press_qualifier (
    input  logic              clk,
    input  logic              rst_n,
    bclp_cfg_if.sink          cfg,
    bclp_in_if.sink           button,
    bclp_out_if.source        result
);

    bclp_pkg::bclp_cfg_t       cfg_reg;
    bclp_pkg::click_status_t   click_status;
    logic                      long_press;
    logic                      pressed;
    logic                      advance;
    logic                      valid_reg;
    logic                      click_reg;
    logic                      long_reg;

    // Configuration: accept every write, mask to register width
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.button_select  <= bclp_pkg::SELECT_RESET;
            cfg_reg.long_threshold <= bclp_pkg::THRESHOLD_RESET;
            cfg_reg.press_filter   <= bclp_pkg::FILTER_RESET;
            cfg_reg.release_gap    <= bclp_pkg::GAP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                bclp_pkg::CFG_BUTTON_SELECT:
                    cfg_reg.button_select  <= cfg.data[bclp_pkg::SEL_W-1:0];
                bclp_pkg::CFG_LONG_THRESHOLD:
                    cfg_reg.long_threshold <= cfg.data[bclp_pkg::COUNT_W-1:0];
                bclp_pkg::CFG_PRESS_FILTER:
                    cfg_reg.press_filter   <= cfg.data[bclp_pkg::FILTER_W-1:0];
                bclp_pkg::CFG_RELEASE_GAP:
                    cfg_reg.release_gap    <= cfg.data[bclp_pkg::GAP_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Take a new tick whenever the result slot is empty or being emptied
    assign button.ready = !valid_reg || result.ready;
    assign advance      = button.valid && button.ready;

    // Line select: an out-of-range selector reads as pressed
    always_comb
    begin
        case (cfg_reg.button_select)
            3'd1:    pressed = !button.line_levels[0];
            3'd2:    pressed = !button.line_levels[1];
            3'd3:    pressed = !button.line_levels[2];
            3'd4:    pressed = !button.line_levels[3];
            default: pressed = 1'b1;
        endcase
    end

    // Click machine runs first; its lockout end clears the long-press machine
    bclp_click_fsm u_click (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .pressed (pressed),
        .cfg     (cfg_reg),
        .status  (click_status)
    );

    bclp_long_fsm u_long (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .pressed      (pressed),
        .cfg          (cfg_reg),
        .click_status (click_status),
        .long_press   (long_press)
    );

    // Result register: load on a tick, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            click_reg <= click_status.click;
            long_reg  <= long_press;
        end
    end

    assign result.valid      = valid_reg;
    assign result.click      = click_reg;
    assign result.long_press = long_reg;

endmodule

@@ rtl/core/bclp_click_fsm.sv @@
// ----------------------------------------------------------------------------
// bclp_click_fsm
// Press filter, capped hold counter, click decision and release lockout.
// ----------------------------------------------------------------------------
module bclp_click_fsm (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           pressed,
    input  bclp_pkg::bclp_cfg_t            cfg,
    output bclp_pkg::click_status_t        status
);

    bclp_pkg::click_phase_t             phase_reg, phase_next;
    logic [bclp_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [bclp_pkg::COUNT_W-1:0]       count_inc;
    logic [bclp_pkg::COUNT_W-1:0]       count_held;
    logic                               release_seen;
    logic                               gap_done;

    assign count_inc    = count_reg + 1'b1;
    assign count_held   = (count_reg < bclp_pkg::HOLD_CAP) ? count_inc : count_reg;
    assign release_seen = !pressed
                          && (count_held > {7'd0, cfg.press_filter});
    assign gap_done     = count_inc > {3'd0, cfg.release_gap};

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        unique case (phase_reg)
            bclp_pkg::CLICK_IDLE:
            begin
                if (pressed)
                begin
                    if (count_inc > {7'd0, cfg.press_filter})
                    begin
                        count_next = '0;
                        phase_next = bclp_pkg::CLICK_HELD;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                else
                begin
                    count_next = '0;
                end
            end
            bclp_pkg::CLICK_HELD:
            begin
                if (release_seen)
                begin
                    count_next = '0;
                    phase_next = bclp_pkg::CLICK_LOCKOUT;
                end
                else
                begin
                    count_next = count_held;
                end
            end
            bclp_pkg::CLICK_LOCKOUT:
            begin
                if (gap_done)
                begin
                    count_next = '0;
                    phase_next = bclp_pkg::CLICK_IDLE;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            default:
            begin
                phase_next = phase_reg;
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        status = '0;
        unique case (phase_reg)
            bclp_pkg::CLICK_HELD:
            begin
                status.click = release_seen && (count_held < cfg.long_threshold);
            end
            bclp_pkg::CLICK_LOCKOUT:
            begin
                status.clear_all = gap_done;
            end
            default:
            begin
                status = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bclp_pkg::CLICK_IDLE;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/bclp_long_fsm.sv @@
// ----------------------------------------------------------------------------
// bclp_long_fsm
// Continuous-press counter with one long-press pulse, release wait and lockout.
// ----------------------------------------------------------------------------
module bclp_long_fsm (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           pressed,
    input  bclp_pkg::bclp_cfg_t            cfg,
    input  bclp_pkg::click_status_t        click_status,
    output logic                           long_press
);

    bclp_pkg::long_phase_t              phase_reg, phase_next, phase_cur;
    logic [bclp_pkg::COUNT_W-1:0]       count_reg, count_next, count_cur;
    logic [bclp_pkg::COUNT_W-1:0]       count_inc;
    logic [bclp_pkg::COUNT_W-1:0]       count_held;
    logic                               reached;

    // The click lockout end clears this machine before it runs on the same tick
    assign phase_cur  = click_status.clear_all ? bclp_pkg::LONG_IDLE : phase_reg;
    assign count_cur  = click_status.clear_all ? '0 : count_reg;
    assign count_inc  = count_cur + 1'b1;
    assign count_held = (count_cur < bclp_pkg::LONG_HOLD_CAP) ? count_inc : count_cur;
    assign reached    = pressed && (count_inc >= cfg.long_threshold);

    always_comb
    begin
        phase_next = phase_cur;
        count_next = count_cur;
        unique case (phase_cur)
            bclp_pkg::LONG_IDLE:
            begin
                if (reached)
                begin
                    count_next = '0;
                    phase_next = bclp_pkg::LONG_FIRED;
                end
                else if (pressed)
                begin
                    count_next = count_inc;
                end
                else
                begin
                    count_next = '0;
                end
            end
            bclp_pkg::LONG_FIRED:
            begin
                if (!pressed && (count_held > {7'd0, cfg.press_filter}))
                begin
                    count_next = '0;
                    phase_next = bclp_pkg::LONG_LOCKOUT;
                end
                else
                begin
                    count_next = count_held;
                end
            end
            bclp_pkg::LONG_LOCKOUT:
            begin
                if (count_inc > {3'd0, cfg.release_gap})
                begin
                    count_next = '0;
                    phase_next = bclp_pkg::LONG_IDLE;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            default:
            begin
                phase_next = phase_cur;
                count_next = count_cur;
            end
        endcase
    end

    always_comb
    begin
        unique case (phase_cur)
            bclp_pkg::LONG_IDLE: long_press = reached;
            default:             long_press = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bclp_pkg::LONG_IDLE;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/bclp_checker.sv @@
// ----------------------------------------------------------------------------
// bclp_checker
// Port-level checks of the button qualifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bclp_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_click,
    input logic out_long_press
);

    // Every accepted tick gives a result in the next cycle
    `ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid)

    // A stalled result blocks the input side
    `ASSERT_IMPLY(a_stall_blocks, clk, rst_n, out_valid && !out_ready, !in_ready)

    // A result never appears without an accepted tick
    `ASSERT_IMPLY(a_no_invented, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready))

    // A click ends on a release, a long press fires while held
    `ASSERT_IMPLY(a_flags_exclusive, clk, rst_n, out_valid, !(out_click && out_long_press))

    // Hold a stalled result
    `ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_click) && $stable(out_long_press))

endmodule

bind button_click_long_press_qualifier bclp_checker u_bclp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (button.valid),
    .in_ready       (button.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_click      (result.click),
    .out_long_press (result.long_press)
);
